>>> rtl/core/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

    // table geometry
    localparam int TABLE_ENTRIES_DEF = 64;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 8'd1;

    localparam logic [15:0] ATTEMPT_LIMIT_RST = 16'd10;
    localparam logic [31:0] WINDOW_TICKS_RST  = 32'd60;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // one table entry as stored in the ram
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] last_time;
        logic [15:0] attempts;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_last;
        logic scan_done;
        logic out_blocked;
    } status_t;

endpackage

>>> rtl/core/sal_req_if.sv
`timescale 1ns / 1ps

interface sal_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_addr;
    logic [31:0] time_now;

    modport source (output valid, output source_addr, output time_now, input ready);
    modport sink (input valid, input source_addr, input time_now, output ready);
endinterface

>>> rtl/core/sal_rsp_if.sv
`timescale 1ns / 1ps

interface sal_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic        table_full;
    logic [15:0] attempt_count;

    modport source (output valid, output allowed, output table_full, output attempt_count,
                    input ready);
    modport sink (input valid, input allowed, input table_full, input attempt_count,
                  output ready);
endinterface

>>> rtl/core/sal_cfg_if.sv
`timescale 1ns / 1ps

interface sal_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sal_pkg::CFG_IDX_W-1:0]  index;
    logic [sal_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/sal_ram.sv
`timescale 1ns / 1ps

module sal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sal_ctrl.sv
`timescale 1ns / 1ps

module sal_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sal_pkg::status_t status,
    output sal_pkg::cmd_t    cmd
);

    sal_pkg::state_t state_reg;
    sal_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sal_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sal_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.idx_last)
                begin
                    state_next = sal_pkg::ST_IDLE;
                end
            end
            sal_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sal_pkg::ST_SCAN;
                end
            end
            sal_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = sal_pkg::ST_UPDATE;
                end
            end
            sal_pkg::ST_UPDATE:
            begin
                // wait until the output register can take the result
                if (!status.out_blocked)
                begin
                    cmd.update = 1'b1;
                    state_next = sal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sal_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/core/sal_dp.sv
`timescale 1ns / 1ps

module sal_dp #(
    parameter int TABLE_ENTRIES = sal_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sal_pkg::cmd_t                  cmd,
    output sal_pkg::status_t               status,
    input  logic [31:0]                    in_source_addr,
    input  logic [31:0]                    in_time_now,
    input  logic                           cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sal_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_allowed,
    output logic                           out_table_full,
    output logic [15:0]                    out_attempt_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam int ENTRY_W = $bits(sal_pkg::entry_t);

    // configuration
    logic [15:0] limit_reg;
    logic [31:0] window_reg;

    // request under work
    logic [31:0] req_addr_reg;
    logic [31:0] req_time_reg;

    // scan control
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issue_done_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    // scan results
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [15:0]      hit_count_reg;
    logic             slot_found_reg;
    logic [IDX_W-1:0] slot_idx_reg;

    // output register
    logic        out_valid_reg;
    logic        out_allowed_reg;
    logic        out_full_reg;
    logic [15:0] out_count_reg;

    sal_pkg::entry_t  rd_entry;
    sal_pkg::entry_t  wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      entry_age;
    logic             entry_aged;
    logic             entry_live;
    logic             entry_match;
    logic [15:0]      count_inc;
    logic             upd_write;

    sal_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_entry),
        .raddr(rd_idx_reg),
        .rdata(rd_word)
    );

    assign rd_entry = sal_pkg::entry_t'(rd_word);

    // per entry check: aging, match, free slot
    assign entry_age   = req_time_reg - rd_entry.last_time;
    assign entry_aged  = rd_entry.valid && (entry_age > window_reg);
    assign entry_live  = rd_entry.valid && !entry_aged;
    assign entry_match = entry_live && (rd_entry.addr == req_addr_reg);

    assign count_inc = (hit_count_reg == sal_pkg::COUNT_MAX) ? hit_count_reg
                                                             : hit_count_reg + 16'd1;
    assign upd_write = hit_found_reg || slot_found_reg;

    // write port select: clearing pass, aging, final update
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_idx_reg;
        wr_entry  = '0;
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_reg;
        end
        else if (cmd.scan && chk_vld_reg && entry_aged)
        begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_reg;
        end
        else if (cmd.update && upd_write)
        begin
            ram_we             = 1'b1;
            ram_waddr          = hit_found_reg ? hit_idx_reg : slot_idx_reg;
            wr_entry.valid     = 1'b1;
            wr_entry.addr      = req_addr_reg;
            wr_entry.last_time = req_time_reg;
            wr_entry.attempts  = hit_found_reg ? count_inc : 16'd1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= sal_pkg::ATTEMPT_LIMIT_RST;
            window_reg <= sal_pkg::WINDOW_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sal_pkg::CFG_ATTEMPT_LIMIT)
            begin
                limit_reg <= cfg_data[15:0];
            end
            else if (cfg_index == sal_pkg::CFG_WINDOW_TICKS)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_addr_reg <= in_source_addr;
            req_time_reg <= in_time_now;
        end
    end

    // index counter and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
        end
        else
        begin
            chk_vld_reg <= cmd.scan && !issue_done_reg;
            chk_idx_reg <= rd_idx_reg;
            if (cmd.start)
            begin
                rd_idx_reg     <= '0;
                issue_done_reg <= 1'b0;
            end
            else if (cmd.clear || (cmd.scan && !issue_done_reg))
            begin
                if (rd_idx_reg == IDX_LAST)
                begin
                    issue_done_reg <= 1'b1;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
        end
    end

    // first hit and first free entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            slot_found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            hit_found_reg  <= 1'b0;
            slot_found_reg <= 1'b0;
        end
        else if (cmd.scan && chk_vld_reg)
        begin
            if (entry_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (!entry_live && !slot_found_reg)
            begin
                slot_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && chk_vld_reg)
        begin
            if (entry_match && !hit_found_reg)
            begin
                hit_idx_reg   <= chk_idx_reg;
                hit_count_reg <= rd_entry.attempts;
            end
            if (!entry_live && !slot_found_reg)
            begin
                slot_idx_reg <= chk_idx_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (hit_found_reg)
            begin
                out_allowed_reg <= (count_inc <= limit_reg);
                out_full_reg    <= 1'b0;
                out_count_reg   <= count_inc;
            end
            else if (slot_found_reg)
            begin
                out_allowed_reg <= 1'b1;
                out_full_reg    <= 1'b0;
                out_count_reg   <= 16'd1;
            end
            else
            begin
                out_allowed_reg <= 1'b1;
                out_full_reg    <= 1'b1;
                out_count_reg   <= 16'd0;
            end
        end
    end

    assign status.idx_last    = (rd_idx_reg == IDX_LAST);
    assign status.scan_done   = chk_vld_reg && (chk_idx_reg == IDX_LAST);
    assign status.out_blocked = out_valid_reg && !out_ready;

    assign out_valid         = out_valid_reg;
    assign out_allowed       = out_allowed_reg;
    assign out_table_full    = out_full_reg;
    assign out_attempt_count = out_count_reg;

endmodule

>>> rtl/core/source_address_attempt_limiter_core.sv
`timescale 1ns / 1ps

// Per-source connection attempt limiter. Each request carries a source address
// and the current tick count; the block ages out table entries older than the
// window, counts the attempt against the address and answers allowed, table_full
// and the updated attempt count. The table lives in a single-port-write,
// registered-read RAM that a controller sweeps one entry per cycle. Requests
// are taken one at a time: each is accepted in the idle state, scanned through
// the read pipeline and written back in an update state, which waits while the
// previous result is still unread. A finished result waits in an output
// register while the next request is taken. After reset a clearing pass empties
// the table before the first request is accepted; configuration writes are
// always accepted and take effect at once.
module source_address_attempt_limiter_core #(
    parameter int TABLE_ENTRIES = sal_pkg::TABLE_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sal_req_if.sink   attempt,
    sal_rsp_if.source result,
    sal_cfg_if.sink   cfg
);

    sal_pkg::cmd_t    cmd;
    sal_pkg::status_t status;

    assign cfg.ready = 1'b1;

    // sequencer
    sal_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(attempt.valid),
        .in_ready(attempt.ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table, scan and result datapath
    sal_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_source_addr   (attempt.source_addr),
        .in_time_now      (attempt.time_now),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_allowed      (result.allowed),
        .out_table_full   (result.table_full),
        .out_attempt_count(result.attempt_count)
    );

endmodule

>>> verif/source_address_attempt_limiter_core_tb.sv
`timescale 1ns / 1ps

module source_address_attempt_limiter_core_tb;

    localparam int ENTRIES      = sal_pkg::TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_IDLE     = 8;

    // indexes past the last register, writes there must be dropped
    localparam logic [sal_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_NEXT =
        sal_pkg::CFG_WINDOW_TICKS + 8'd1;
    localparam logic [sal_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_TOP  = '1;

    // one answer of the limiter
    typedef struct packed {
        logic        allowed;
        logic        table_full;
        logic [15:0] attempt_count;
    } verdict_t;

    // tracks the address table, predicts verdicts and checks answers in order
    class admission_book;
        logic [15:0] limit;
        logic [31:0] window;
        logic        live [ENTRIES];
        logic [31:0] owner [ENTRIES];
        logic [31:0] last_seen [ENTRIES];
        logic [15:0] tries [ENTRIES];
        verdict_t    pending [$];
        int          mismatches;

        function new();
            limit      = sal_pkg::ATTEMPT_LIMIT_RST;
            window     = sal_pkg::WINDOW_TICKS_RST;
            mismatches = 0;
            foreach (live[i])
            begin
                live[i]      = 1'b0;
                owner[i]     = '0;
                last_seen[i] = '0;
                tries[i]     = '0;
            end
        endfunction

        function void write_reg(logic [sal_pkg::CFG_IDX_W-1:0] index,
                                logic [sal_pkg::CFG_DATA_W-1:0] data);
            case (index)
                sal_pkg::CFG_ATTEMPT_LIMIT: limit = data[15:0];
                sal_pkg::CFG_WINDOW_TICKS:  window = data;
                default: ;
            endcase
        endfunction

        function int waiting();
            return pending.size();
        endfunction

        function void note_attempt(logic [31:0] addr, logic [31:0] now);
            verdict_t    v;
            logic [31:0] age;
            int          hit;
            int          slot;
            hit  = -1;
            slot = -1;
            // free entries older than the window, age wraps modulo 2^32
            for (int i = 0; i < ENTRIES; i++)
            begin
                age = now - last_seen[i];
                if (live[i] && age > window)
                    live[i] = 1'b0;
            end
            // address match and lowest free entry
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (live[i] && owner[i] == addr && hit < 0)
                    hit = i;
                if (!live[i] && slot < 0)
                    slot = i;
            end
            if (hit >= 0)
            begin
                last_seen[hit] = now;
                if (tries[hit] != sal_pkg::COUNT_MAX)
                    tries[hit] = tries[hit] + 16'd1;
                v.allowed       = (tries[hit] > limit) ? 1'b0 : 1'b1;
                v.table_full    = 1'b0;
                v.attempt_count = tries[hit];
            end
            else if (slot >= 0)
            begin
                live[slot]      = 1'b1;
                owner[slot]     = addr;
                last_seen[slot] = now;
                tries[slot]     = 16'd1;
                v.allowed       = 1'b1;
                v.table_full    = 1'b0;
                v.attempt_count = 16'd1;
            end
            else
            begin
                // no room: admitted but not recorded
                v.allowed       = 1'b1;
                v.table_full    = 1'b1;
                v.attempt_count = 16'd0;
            end
            pending.insert(pending.size(), v);
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: answer with nothing pending, expected none, actual %0b/%0b/%0d",
                         $time, got.allowed, got.table_full, got.attempt_count);
                return;
            end
            want = pending.pop_front();
            if (got.allowed !== want.allowed)
            begin
                mismatches++;
                $display("%0t: allowed expected %0b actual %0b",
                         $time, want.allowed, got.allowed);
            end
            if (got.table_full !== want.table_full)
            begin
                mismatches++;
                $display("%0t: table_full expected %0b actual %0b",
                         $time, want.table_full, got.table_full);
            end
            if (got.attempt_count !== want.attempt_count)
            begin
                mismatches++;
                $display("%0t: attempt_count expected %0d actual %0d",
                         $time, want.attempt_count, got.attempt_count);
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    bit            sender_quiet = 1'b0;
    bit            receiver_quiet = 1'b0;
    int            cycle_count;
    int            random_sent;
    admission_book book;

    sal_req_if attempt_ch();
    sal_rsp_if result_ch();
    sal_cfg_if cfg_ch();

    source_address_attempt_limiter_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .attempt(attempt_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_idle(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
    endfunction

    // offer one request, valid stays up after acceptance for back-to-back use
    task automatic send_attempt(input logic [31:0] addr, input logic [31:0] now);
        int gap;
        gap = draw_idle(sender_quiet);
        if (gap > 0)
        begin
            attempt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        attempt_ch.valid       <= 1'b1;
        attempt_ch.source_addr <= addr;
        attempt_ch.time_now    <= now;
        @(posedge clk);
        while (attempt_ch.ready !== 1'b1)
            @(posedge clk);
        book.note_attempt(addr, now);
    endtask

    // register write, valid dropped only after the last one of a batch
    task automatic write_reg(input logic [sal_pkg::CFG_IDX_W-1:0] index,
                             input logic [sal_pkg::CFG_DATA_W-1:0] data, input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        book.write_reg(index, data);
        if (last)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [sal_pkg::CFG_DATA_W-1:0] limit_data,
                              input logic [sal_pkg::CFG_DATA_W-1:0] window_data);
        write_reg(sal_pkg::CFG_ATTEMPT_LIMIT, limit_data, 1'b0);
        write_reg(sal_pkg::CFG_WINDOW_TICKS, window_data, 1'b1);
    endtask

    // block goes idle once every pending answer has come back
    task automatic drain();
        attempt_ch.valid <= 1'b0;
        while (book.waiting() != 0)
            @(posedge clk);
    endtask

    // one random setting: registers, address pool and time walk
    task automatic run_phase(input bit fill_table);
        logic [31:0] pool [$];
        logic [31:0] tick;
        logic [31:0] addr;
        logic [15:0] limit_val;
        logic [31:0] window_val;
        int          pool_size;
        int          step_max;
        int          count;
        int          pick;
        drain();
        sender_quiet   = ($urandom_range(0, 3) == 0);
        receiver_quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 6))
            0: limit_val = 16'd0;
            1: limit_val = 16'd1;
            2: limit_val = 16'd2;
            3: limit_val = 16'd3;
            4: limit_val = 16'd10;
            5: limit_val = 16'hFFFF;
            default: limit_val = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 6))
            0: window_val = 32'd0;
            1: window_val = 32'd1;
            2: window_val = 32'd8;
            3: window_val = 32'd60;
            4: window_val = 32'd400;
            5: window_val = '1;
            default: window_val = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: pool_size = 3;
            1: pool_size = 12;
            2: pool_size = 40;
            3: pool_size = 70;
            default: pool_size = 120;
        endcase
        case ($urandom_range(0, 3))
            0: step_max = 0;
            1: step_max = 1;
            2: step_max = 4;
            default: step_max = 20;
        endcase
        count = $urandom_range(100, 220);
        // more live addresses than entries with nothing aging out
        if (fill_table)
        begin
            window_val = '1;
            pool_size  = 80;
            count      = 170;
        end
        // keep the total near the planned item count
        if (count > RANDOM_ITEMS - random_sent)
            count = RANDOM_ITEMS - random_sent;
        set_limits({16'($urandom), limit_val}, window_val);

        for (int i = 0; i < pool_size; i++)
            pool.insert(pool.size(), $urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            pool[0] = '0;
            pool[1] = '1;
        end

        tick = $urandom;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            // mostly forward steps, now and then time runs back or jumps
            if (pick < 3)
                tick = tick - 32'($urandom_range(1, 50));
            else if (pick < 5)
                tick = $urandom;
            else
                tick = tick + 32'($urandom_range(0, step_max));
            // a few strangers among the known addresses
            if (pick >= 92)
                addr = $urandom;
            else
                addr = pool[$urandom_range(0, pool_size - 1)];
            send_attempt(addr, tick);
        end
        random_sent += count;
    endtask

    // answer side with random stalls
    initial
    begin
        int       stall;
        verdict_t got;
        result_ch.ready = 1'b0;
        forever
        begin
            stall = draw_idle(receiver_quiet);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
            got.allowed       = result_ch.allowed;
            got.table_full    = result_ch.table_full;
            got.attempt_count = result_ch.attempt_count;
            book.check_result(got);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        book = new();
        random_sent            = 0;
        rst_n                  = 1'b0;
        attempt_ch.valid       = 1'b0;
        attempt_ch.source_addr = '0;
        attempt_ch.time_now    = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: age equal to the window survives, one more frees
        send_attempt(32'h0000_0000, 32'd0);
        send_attempt(32'h0000_0000, 32'd60);
        send_attempt(32'hFFFF_FFFF, 32'd61);
        send_attempt(32'h0000_0000, 32'd121);
        drain();

        // limit two, window five, stray writes to unmapped indexes
        write_reg(sal_pkg::CFG_ATTEMPT_LIMIT, 32'hFFFF_0002, 1'b0);
        write_reg(sal_pkg::CFG_WINDOW_TICKS, 32'd5, 1'b0);
        write_reg(CFG_UNMAPPED_NEXT, 32'd0, 1'b0);
        write_reg(CFG_UNMAPPED_TOP, 32'hFFFF_FFFF, 1'b1);
        send_attempt(32'hC0A8_0001, 32'd1000);
        send_attempt(32'hC0A8_0001, 32'd1001);
        send_attempt(32'hC0A8_0001, 32'd1002);
        send_attempt(32'hC0A8_0001, 32'd1003);
        send_attempt(32'hC0A8_0001, 32'd1009);
        drain();

        // zero limit refuses every repeat, zero window frees any nonzero age
        set_limits(32'd0, 32'd0);
        send_attempt(32'hC0A8_0001, 32'd1009);
        send_attempt(32'hC0A8_0001, 32'd1010);
        send_attempt(32'hC0A8_0001, 32'd1009);
        drain();

        // widest limit and window, time wraps through zero
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_attempt(32'hC0A8_0001, 32'hFFFF_FFFF);
        send_attempt(32'hC0A8_0001, 32'h0000_0000);
        send_attempt(32'h7FFF_FFFF, 32'h8000_0000);
        send_attempt(32'h8000_0000, 32'h7FFF_FFFF);

        run_phase(1'b1);
        while (random_sent < RANDOM_ITEMS)
            run_phase(1'b0);
        drain();
        repeat (ENTRIES + 8) @(posedge clk);

        if (book.mismatches == 0 && book.waiting() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sal_pkg.sv
rtl/core/sal_req_if.sv
rtl/core/sal_rsp_if.sv
rtl/core/sal_cfg_if.sv
rtl/core/sal_ram.sv
rtl/core/sal_ctrl.sv
rtl/core/sal_dp.sv
rtl/core/source_address_attempt_limiter_core.sv
verif/source_address_attempt_limiter_core_tb.sv
